// ----- rtl/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg: shared types and codes for the rational arithmetic unit
// Opcodes, sign and compare codes, beat payloads and the iterative unit's
// control word.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int FIELD_W = 32;

  // opcodes
  localparam logic [3:0] OP_REDUCE = 4'd0;
  localparam logic [3:0] OP_ADD    = 4'd1;
  localparam logic [3:0] OP_SUB    = 4'd2;
  localparam logic [3:0] OP_MUL    = 4'd3;
  localparam logic [3:0] OP_DIV    = 4'd4;
  localparam logic [3:0] OP_SCALE  = 4'd5;
  localparam logic [3:0] OP_EQ     = 4'd6;
  localparam logic [3:0] OP_NE     = 4'd7;
  localparam logic [3:0] OP_GT     = 4'd8;
  localparam logic [3:0] OP_LT     = 4'd9;
  localparam logic [3:0] OP_GE     = 4'd10;
  localparam logic [3:0] OP_LE     = 4'd11;

  // sign codes
  localparam logic [1:0] SGN_PLUS  = 2'd0;
  localparam logic [1:0] SGN_MINUS = 2'd1;
  localparam logic [1:0] SGN_NAN   = 2'd2;

  // compare answers
  localparam logic [1:0] CMP_FALSE   = 2'd0;
  localparam logic [1:0] CMP_TRUE    = 2'd1;
  localparam logic [1:0] CMP_UNKNOWN = 2'd2;

  typedef enum logic [1:0] {
    UOP_GCD,
    UOP_DIV,
    UOP_MUL
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_ctl_t;

  typedef struct packed {
    logic [3:0]         req_type;
    logic [31:0]        a_num;
    logic [31:0]        a_den;
    logic [1:0]         a_sign;
    logic [31:0]        b_num;
    logic [31:0]        b_den;
    logic [1:0]         b_sign;
    logic signed [31:0] scale_const;
  } req_t;

  typedef struct packed {
    logic [31:0] res_num;
    logic [31:0] res_den;
    logic [1:0]  res_sign;
    logic [1:0]  cmp_result;
    logic        overflow;
  } rsp_t;

endpackage

// ----- rtl/rau_chan_if.sv -----
// ----------------------------------------------------------------------------
// rau_chan_if: valid/ready channel
// Carries one payload beat per valid and ready handshake.
// ----------------------------------------------------------------------------
interface rau_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/rau_iter_unit.sv -----
// ----------------------------------------------------------------------------
// rau_iter_unit: shared iterative gcd / divide / multiply unit
// Binary gcd one step a cycle, restoring divide and shift-add multiply one
// bit a cycle, all through one add/subtract path. Done pulses for a cycle.
// ----------------------------------------------------------------------------
module rau_iter_unit #(
  parameter int DW = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  rau_pkg::unit_ctl_t  ctl,
  input  logic [DW-1:0]       x,
  input  logic [DW-1:0]       y,
  output logic                done,
  output logic [DW-1:0]       lo,
  output logic [DW-1:0]       hi
);
  import rau_pkg::*;

  localparam int CW = $clog2(DW);
  localparam int KW = $clog2(DW + 1);

  logic [DW-1:0] u;
  logic [DW-1:0] v;
  logic [DW-1:0] d;
  logic [CW-1:0] cnt;
  logic [KW-1:0] k;
  logic          busy;
  unit_op_t      op;

  logic [DW:0]   add_a;
  logic [DW:0]   add_b;
  logic [DW:0]   add_s;
  logic          add_sub;
  logic [DW:0]   rem_sh;
  logic          qbit;
  logic [DW-1:0] gdiff_neg;

  // shared add/subtract path
  always_comb begin
    rem_sh  = {u, v[DW-1]};
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (op)
      UOP_DIV: begin
        add_a   = rem_sh;
        add_b   = {1'b0, d};
        add_sub = 1'b1;
      end
      UOP_MUL: begin
        add_a = {1'b0, u};
        add_b = v[0] ? {1'b0, d} : '0;
      end
      default: begin
        add_a   = {1'b0, u};
        add_b   = {1'b0, v};
        add_sub = 1'b1;
      end
    endcase
    add_s     = add_a + (add_sub ? ~add_b : add_b) + {{DW{1'b0}}, add_sub};
    gdiff_neg = ~add_s[DW-1:0] + {{(DW-1){1'b0}}, 1'b1};
    qbit      = ~add_s[DW];
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        op   <= ctl.op;
        k    <= '0;
        cnt  <= CW'(DW - 1);
        case (ctl.op)
          UOP_DIV: begin
            u <= '0;
            v <= x;
            d <= y;
          end
          UOP_MUL: begin
            u <= '0;
            v <= y;
            d <= x;
          end
          default: begin
            u <= x;
            v <= y;
            d <= '0;
          end
        endcase
      end else if (busy) begin
        case (op)
          UOP_DIV: begin
            u   <= qbit ? add_s[DW-1:0] : rem_sh[DW-1:0];
            v   <= {v[DW-2:0], qbit};
            cnt <= cnt - 1'b1;
            if (cnt == '0) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          UOP_MUL: begin
            u   <= add_s[DW:1];
            v   <= {add_s[0], v[DW-1:1]};
            cnt <= cnt - 1'b1;
            if (cnt == '0) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          default: begin
            if (u == '0 || v == '0) begin
              v    <= (u | v) << k;
              u    <= '0;
              busy <= 1'b0;
              done <= 1'b1;
            end else if (!u[0] && !v[0]) begin
              u <= u >> 1;
              v <= v >> 1;
              k <= k + 1'b1;
            end else if (!u[0]) begin
              u <= u >> 1;
            end else if (!v[0]) begin
              v <= v >> 1;
            end else if (!add_s[DW]) begin
              u <= add_s[DW-1:0];
            end else begin
              v <= gdiff_neg;
            end
          end
        endcase
      end
    end
  end

  assign lo = v;
  assign hi = u;

endmodule

// ----- rtl/rational_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: sign-magnitude fraction ALU
// Reduce, add, subtract, multiply, divide, scale and compare of two
// fractions, with every gcd, quotient and product done on one shared unit.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one beat per item: opcode, two fractions and a scale
//   constant. rsp returns exactly one beat per item: numerator, denominator,
//   sign, compare answer and overflow flag.
//   req.ready is high only while the sequencer is idle; one item is in work
//   at a time. Special cases (NaN, infinity, zero, identity) are settled in
//   decode. Other items run a chain of steps on the iterative unit, which is
//   DW = max(WIDTH, 32) bits wide. Add runs 2 gcds, 4 divides and 3
//   multiplies, multiply and divide 2 gcds, 4 divides and 2 multiplies,
//   compares up to 1 gcd, 2 divides and 2 multiplies, scale 1 gcd, 2
//   divides and 1 multiply.
//   The result sits in an output register: a new item is accepted while it
//   waits, and a stalled receiver only holds the next result back.
//   Reset clears the sequencer and drops any pending result.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
  parameter int WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  rau_chan_if.sink   req,
  rau_chan_if.source rsp
);
  import rau_pkg::*;

  localparam int DW = (WIDTH > FIELD_W) ? WIDTH : FIELD_W;
  localparam logic [DW-1:0]   MASK  = {DW{1'b1}} >> (DW - WIDTH);
  localparam logic [2*DW-1:0] PMASK = {(2*DW){1'b1}} >> (2*DW - WIDTH);
  localparam logic [DW-1:0]   ONE   = {{(DW-1){1'b0}}, 1'b1};

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE,
    S_XG, S_XQ1, S_XQ2, S_XM1, S_XM2, S_XM3, S_XSUM,
    S_RG, S_RQ1, S_RQ2,
    S_MG1, S_MG2, S_MQ1, S_MQ2, S_MQ3, S_MQ4, S_MM1, S_MM2,
    S_SG, S_SQ1, S_SQ2, S_SM,
    S_DONE
  } st_t;

  st_t state;
  st_t dec_state;

  // operand and working registers
  logic [3:0]      opc;
  logic [DW-1:0]   ax, ay, bx, by, mag;
  logic [1:0]      a_s, b_s;
  logic            sneg;
  logic [DW-1:0]   c, t1, t2, rx, ry;
  logic [1:0]      rs;
  logic [1:0]      rcmp;
  logic            ovf;
  logic [2*DW-1:0] p1;
  logic            launched;
  logic            oval;
  rsp_t            odata;

  // iterative unit hookup
  unit_ctl_t       unit_ctl;
  logic            calc;
  logic [DW-1:0]   ux, uy;
  logic            u_done;
  logic [DW-1:0]   u_lo, u_hi;

  rau_iter_unit #(
    .DW (DW)
  ) u_iter (
    .clk  (clk),
    .rst  (rst),
    .ctl  (unit_ctl),
    .x    (ux),
    .y    (uy),
    .done (u_done),
    .lo   (u_lo),
    .hi   (u_hi)
  );

  // operand classes
  logic [1:0]      b_se, psign;
  logic            a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic            a_pinf, a_minf, b_pinf, b_minf, a_id, b_id, bi_id, is_cmp;
  logic [FIELD_W-1:0] sc_raw, sc_mag;

  always_comb begin
    b_se   = (opc == OP_SUB) ? (b_s ^ SGN_MINUS) : b_s;
    a_nan  = a_s[1] || (ax == MASK && ay == MASK);
    b_nan  = b_s[1] || (bx == MASK && by == MASK);
    a_inf  = (ay == '0);
    b_inf  = (by == '0);
    a_zero = (ax == '0);
    b_zero = (bx == '0);
    a_pinf = a_inf && a_s == SGN_PLUS;
    a_minf = a_inf && a_s == SGN_MINUS;
    b_pinf = b_inf && b_se == SGN_PLUS;
    b_minf = b_inf && b_se == SGN_MINUS;
    a_id   = ax == ONE && ay == ONE && a_s == SGN_PLUS;
    b_id   = bx == ONE && by == ONE && b_se == SGN_PLUS;
    bi_id  = by == ONE && bx == ONE && b_s == SGN_PLUS;
    psign  = (a_s == b_s) ? SGN_PLUS : SGN_MINUS;
    is_cmp = (opc >= OP_EQ) && (opc <= OP_LE);
    sc_raw = req.data.scale_const;
    sc_mag = sc_raw[FIELD_W-1] ? (~sc_raw + 1'b1) : sc_raw;
  end

  // where decode goes: long paths run on the shared unit
  always_comb begin
    dec_state = S_DONE;
    case (opc)
      OP_REDUCE: begin
        if (!a_s[1] && !a_inf && !a_zero) dec_state = S_RG;
      end
      OP_ADD, OP_SUB: begin
        if (!a_nan && !b_nan && !a_inf && !b_inf && !a_zero && !b_zero) dec_state = S_XG;
      end
      OP_MUL: begin
        if (!a_nan && !b_nan && !a_inf && !b_inf && !a_zero && !b_zero && !a_id && !b_id)
          dec_state = S_MG1;
      end
      OP_DIV: begin
        if (!a_nan && !b_nan && !a_inf && !b_inf && !a_zero && !b_zero && !a_id && !bi_id)
          dec_state = S_MG1;
      end
      OP_SCALE: begin
        if (!a_nan && !a_zero && mag != '0 && !a_inf) dec_state = S_SG;
      end
      OP_EQ, OP_NE, OP_GT, OP_LT, OP_GE, OP_LE: begin
        if (!a_nan && !b_nan && !a_inf && !b_inf && opc != OP_EQ && opc != OP_NE
            && a_s == b_s)
          dec_state = S_XG;
      end
      default: dec_state = S_DONE;
    endcase
  end

  // product truncation, overflow and ordering of the cross products
  logic [2*DW-1:0] cur;
  logic [DW-1:0]   cur_lo, p1_lo;
  logic            cur_ovf, p1_ovf;
  logic            ord_gt, ord_lt;

  always_comb begin
    cur     = {u_hi, u_lo};
    cur_lo  = u_lo & MASK;
    cur_ovf = |(cur & ~PMASK);
    p1_lo   = p1[DW-1:0] & MASK;
    p1_ovf  = |(p1 & ~PMASK);
    if (a_s == SGN_MINUS) begin
      ord_gt = p1 < cur;
      ord_lt = p1 > cur;
    end else begin
      ord_gt = p1 > cur;
      ord_lt = p1 < cur;
    end
  end

  // signed sum of the scaled numerators
  logic [DW:0]   sum_w;
  logic [DW-1:0] sum_x;
  logic [1:0]    sum_s;
  logic          sum_ovf;

  always_comb begin
    sum_w   = {1'b0, p1_lo} + {1'b0, t2};
    sum_ovf = 1'b0;
    if (a_s == b_s) begin
      sum_x   = sum_w[DW-1:0] & MASK;
      sum_s   = a_s;
      sum_ovf = |(sum_w & ~{1'b0, MASK});
    end else if (a_s == SGN_MINUS) begin
      sum_x = (p1_lo > t2) ? (p1_lo - t2) : (t2 - p1_lo);
      sum_s = (p1_lo > t2) ? SGN_MINUS : SGN_PLUS;
    end else begin
      sum_x = (p1_lo >= t2) ? (p1_lo - t2) : (t2 - p1_lo);
      sum_s = (p1_lo >= t2) ? SGN_PLUS : SGN_MINUS;
    end
  end

  function automatic logic [1:0] cmp_ans(input logic [3:0] code, input logic gt,
                                         input logic lt);
    logic t;
    case (code)
      OP_GT:   t = gt;
      OP_LT:   t = lt;
      OP_GE:   t = !lt;
      default: t = !gt;
    endcase
    return t ? CMP_TRUE : CMP_FALSE;
  endfunction

  // unit operand select per step
  always_comb begin
    calc = 1'b1;
    unit_ctl.op = UOP_GCD;
    ux = '0;
    uy = '0;
    case (state)
      S_XG:  begin unit_ctl.op = UOP_GCD; ux = ay;  uy = by; end
      S_XQ1: begin unit_ctl.op = UOP_DIV; ux = by;  uy = c;  end
      S_XQ2: begin unit_ctl.op = UOP_DIV; ux = ay;  uy = c;  end
      S_XM1: begin unit_ctl.op = UOP_MUL; ux = ax;  uy = t1; end
      S_XM2: begin unit_ctl.op = UOP_MUL; ux = bx;  uy = t2; end
      S_XM3: begin unit_ctl.op = UOP_MUL; ux = ay;  uy = t1; end
      S_RG:  begin unit_ctl.op = UOP_GCD; ux = rx;  uy = ry; end
      S_RQ1: begin unit_ctl.op = UOP_DIV; ux = rx;  uy = c;  end
      S_RQ2: begin unit_ctl.op = UOP_DIV; ux = ry;  uy = c;  end
      S_MG1: begin unit_ctl.op = UOP_GCD; ux = ax;  uy = by; end
      S_MG2: begin unit_ctl.op = UOP_GCD; ux = bx;  uy = ay; end
      S_MQ1: begin unit_ctl.op = UOP_DIV; ux = ax;  uy = c;  end
      S_MQ2: begin unit_ctl.op = UOP_DIV; ux = by;  uy = c;  end
      S_MQ3: begin unit_ctl.op = UOP_DIV; ux = bx;  uy = t2; end
      S_MQ4: begin unit_ctl.op = UOP_DIV; ux = ay;  uy = t2; end
      S_MM1: begin unit_ctl.op = UOP_MUL; ux = ax;  uy = bx; end
      S_MM2: begin unit_ctl.op = UOP_MUL; ux = ay;  uy = by; end
      S_SG:  begin unit_ctl.op = UOP_GCD; ux = mag; uy = ay; end
      S_SQ1: begin unit_ctl.op = UOP_DIV; ux = mag; uy = c;  end
      S_SQ2: begin unit_ctl.op = UOP_DIV; ux = ay;  uy = c;  end
      S_SM:  begin unit_ctl.op = UOP_MUL; ux = t1;  uy = ax; end
      default: calc = 1'b0;
    endcase
    unit_ctl.start = calc && !launched;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      launched <= 1'b0;
      oval     <= 1'b0;
    end else begin
      if (unit_ctl.start) begin
        launched <= 1'b1;
      end else if (u_done) begin
        launched <= 1'b0;
      end
      if (state == S_DONE && (!oval || rsp.ready)) begin
        oval <= 1'b1;
      end else if (rsp.ready) begin
        oval <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            opc   <= req.data.req_type;
            ax    <= DW'(req.data.a_num) & MASK;
            ay    <= DW'(req.data.a_den) & MASK;
            a_s   <= req.data.a_sign;
            bx    <= DW'(req.data.b_num) & MASK;
            by    <= DW'(req.data.b_den) & MASK;
            b_s   <= req.data.b_sign;
            mag   <= DW'(sc_mag);
            sneg  <= sc_raw[FIELD_W-1];
            ovf   <= 1'b0;
            rcmp  <= CMP_FALSE;
            rx    <= '0;
            ry    <= '0;
            rs    <= SGN_PLUS;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          state <= dec_state;
          case (opc)
            OP_REDUCE: begin
              if (a_s[1]) begin
                rx <= MASK; ry <= MASK; rs <= SGN_NAN;
              end else if (a_inf) begin
                rx <= ONE; ry <= '0; rs <= a_s;
              end else if (a_zero) begin
                rx <= '0; ry <= ONE; rs <= SGN_PLUS;
              end else begin
                rx <= ax; ry <= ay; rs <= a_s;
              end
            end
            OP_ADD, OP_SUB: begin
              if (a_nan || b_nan) begin
                rx <= MASK; ry <= MASK; rs <= SGN_NAN;
              end else if (a_inf || b_inf) begin
                if ((a_pinf && b_minf) || (a_minf && b_pinf)) begin
                  rx <= MASK; ry <= MASK; rs <= SGN_NAN;
                end else begin
                  rx <= ONE; ry <= '0;
                  rs <= (a_pinf || b_pinf) ? SGN_PLUS : SGN_MINUS;
                end
              end else if (a_zero) begin
                rx <= bx; ry <= by; rs <= b_se;
              end else if (b_zero) begin
                rx <= ax; ry <= ay; rs <= a_s;
              end else begin
                b_s <= b_se;
              end
            end
            OP_MUL: begin
              if (a_nan || b_nan) begin
                rx <= MASK; ry <= MASK; rs <= SGN_NAN;
              end else if (a_inf || b_inf) begin
                if (a_zero || b_zero) begin
                  rx <= MASK; ry <= MASK; rs <= SGN_NAN;
                end else begin
                  rx <= ONE; ry <= '0; rs <= psign;
                end
              end else if (a_zero || b_zero) begin
                rx <= '0; ry <= ONE; rs <= SGN_PLUS;
              end else if (a_id) begin
                rx <= bx; ry <= by; rs <= b_s;
              end else if (b_id) begin
                rx <= ax; ry <= ay; rs <= a_s;
              end else begin
                rs <= psign;
              end
            end
            OP_DIV: begin
              if (a_nan || b_nan || (a_inf && b_inf) || (a_zero && b_zero && !a_inf
                  && !b_inf)) begin
                rx <= MASK; ry <= MASK; rs <= SGN_NAN;
              end else if (a_inf) begin
                rx <= ax; ry <= ay;
                rs <= a_s ^ ((b_s != SGN_PLUS) ? SGN_MINUS : SGN_PLUS);
              end else if (b_inf) begin
                rx <= '0; ry <= ONE; rs <= SGN_PLUS;
              end else if (b_zero) begin
                rx <= ONE; ry <= '0; rs <= a_s;
              end else if (a_zero) begin
                rx <= '0; ry <= ONE; rs <= SGN_PLUS;
              end else if (a_id) begin
                rx <= by; ry <= bx; rs <= b_s;
              end else if (bi_id) begin
                rx <= ax; ry <= ay; rs <= a_s;
              end else begin
                bx <= by;
                by <= bx;
                rs <= psign;
              end
            end
            OP_SCALE: begin
              if (a_nan) begin
                rx <= MASK; ry <= MASK; rs <= SGN_NAN;
              end else if (a_zero) begin
                rx <= '0; ry <= ONE; rs <= SGN_PLUS;
              end else if (mag == '0) begin
                if (a_inf) begin
                  rx <= MASK; ry <= MASK; rs <= SGN_NAN;
                end else begin
                  rx <= '0; ry <= ONE; rs <= SGN_PLUS;
                end
              end else if (a_inf) begin
                rx <= ax; ry <= ay; rs <= a_s ^ {1'b0, sneg};
              end else begin
                rs <= a_s ^ {1'b0, sneg};
              end
            end
            OP_EQ, OP_NE, OP_GT, OP_LT, OP_GE, OP_LE: begin
              if (a_nan || b_nan) begin
                rcmp <= CMP_UNKNOWN;
              end else if (a_inf || b_inf) begin
                if ((a_pinf && b_pinf) || (a_minf && b_minf)) begin
                  rcmp <= CMP_UNKNOWN;
                end else if (opc == OP_EQ) begin
                  rcmp <= CMP_FALSE;
                end else if (opc == OP_NE) begin
                  rcmp <= CMP_TRUE;
                end else begin
                  rcmp <= cmp_ans(opc, a_pinf || b_minf, !(a_pinf || b_minf));
                end
              end else if (opc == OP_EQ || opc == OP_NE) begin
                rcmp <= ((a_s == b_s && ax == bx && ay == by) == (opc == OP_EQ))
                        ? CMP_TRUE : CMP_FALSE;
              end else if (a_s == SGN_PLUS && b_s == SGN_MINUS) begin
                rcmp <= cmp_ans(opc, 1'b1, 1'b0);
              end else if (a_s == SGN_MINUS && b_s == SGN_PLUS) begin
                rcmp <= cmp_ans(opc, 1'b0, 1'b1);
              end
            end
            default: begin
              rx <= '0; ry <= '0; rs <= SGN_PLUS;
            end
          endcase
        end
        // common denominator: shared by add, subtract and ordering compares
        S_XG:  if (u_done) begin c  <= u_lo; state <= S_XQ1; end
        S_XQ1: if (u_done) begin t1 <= u_lo; state <= S_XQ2; end
        S_XQ2: if (u_done) begin t2 <= u_lo; state <= S_XM1; end
        S_XM1: if (u_done) begin p1 <= cur;  state <= S_XM2; end
        S_XM2: begin
          if (u_done) begin
            if (is_cmp) begin
              rcmp  <= cmp_ans(opc, ord_gt, ord_lt);
              state <= S_DONE;
            end else begin
              t2    <= cur_lo;
              ovf   <= ovf | p1_ovf | cur_ovf;
              state <= S_XM3;
            end
          end
        end
        S_XM3: begin
          if (u_done) begin
            ry    <= cur_lo;
            ovf   <= ovf | cur_ovf;
            state <= S_XSUM;
          end
        end
        S_XSUM: begin
          ovf <= ovf | sum_ovf;
          if (sum_x == '0) begin
            rx <= '0; ry <= ONE; rs <= SGN_PLUS;
            state <= S_DONE;
          end else begin
            rx <= sum_x; rs <= sum_s;
            state <= S_RG;
          end
        end
        // final reduction
        S_RG:  if (u_done) begin c  <= u_lo; state <= S_RQ1; end
        S_RQ1: if (u_done) begin rx <= u_lo; state <= S_RQ2; end
        S_RQ2: if (u_done) begin ry <= u_lo; state <= S_DONE; end
        // cross-cancelled product
        S_MG1: if (u_done) begin c  <= u_lo; state <= S_MG2; end
        S_MG2: if (u_done) begin t2 <= u_lo; state <= S_MQ1; end
        S_MQ1: if (u_done) begin ax <= u_lo; state <= S_MQ2; end
        S_MQ2: if (u_done) begin by <= u_lo; state <= S_MQ3; end
        S_MQ3: if (u_done) begin bx <= u_lo; state <= S_MQ4; end
        S_MQ4: if (u_done) begin ay <= u_lo; state <= S_MM1; end
        S_MM1: begin
          if (u_done) begin
            rx <= cur_lo; ovf <= ovf | cur_ovf; state <= S_MM2;
          end
        end
        S_MM2: begin
          if (u_done) begin
            ry <= cur_lo; ovf <= ovf | cur_ovf; state <= S_DONE;
          end
        end
        // scale by integer constant
        S_SG:  if (u_done) begin c  <= u_lo; state <= S_SQ1; end
        S_SQ1: if (u_done) begin t1 <= u_lo; state <= S_SQ2; end
        S_SQ2: if (u_done) begin ry <= u_lo; state <= S_SM;  end
        S_SM: begin
          if (u_done) begin
            rx <= cur_lo; ovf <= ovf | cur_ovf; state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!oval || rsp.ready) begin
            odata.res_num    <= rx[FIELD_W-1:0];
            odata.res_den    <= ry[FIELD_W-1:0];
            odata.res_sign   <= rs;
            odata.cmp_result <= rcmp;
            odata.overflow   <= ovf;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = oval;
  assign rsp.data  = odata;

  // checks
  ap_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> state == S_DECODE)
    else $error("accepted beat did not reach decode");

  ap_single_launch: assert property (@(posedge clk) disable iff (rst)
    unit_ctl.start |=> !unit_ctl.start)
    else $error("iterative unit launched twice");

  ap_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!oval || rsp.ready)) |=> rsp.valid)
    else $error("finished result not presented");

  ap_cmp_fields: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.data.cmp_result != CMP_FALSE) |->
      (rsp.data.res_num == '0 && rsp.data.res_den == '0))
    else $error("compare beat carries fraction fields");

endmodule
